[rtl/core/rtq_pkg.sv]
`default_nettype none
package rtq_pkg;
   localparam int DataWidth = 16;
   localparam int FracBits = 14;
   // radicand: one + three entries, fits DataWidth + 3 bits signed
   localparam int RadWidth = DataWidth + 3;
   // radicand times ONE, unsigned
   localparam int ProdWidth = RadWidth + FracBits;
   // square root result width
   localparam int RootWidth = (ProdWidth + 1) / 2;
   // numerator: sum or difference of two entries
   localparam int NumWidth = DataWidth + 1;
   // dividend magnitude n * ONE
   localparam int DivWidth = NumWidth + FracBits;
   localparam int DenWidth = RootWidth + 1;
   // quotient width, wide enough to flag saturation
   localparam int QuotWidth = DivWidth;
   localparam int SqrtSteps = RootWidth;
   localparam int DivSteps = QuotWidth;

   typedef enum logic [1:0] {
      SEL_W = 2'd0,
      SEL_X = 2'd1,
      SEL_Y = 2'd2,
      SEL_Z = 2'd3
   } sel_type;

   typedef struct packed {
      logic [DataWidth-1:0] quat_w;
      logic [DataWidth-1:0] quat_x;
      logic [DataWidth-1:0] quat_y;
      logic [DataWidth-1:0] quat_z;
      logic                 bad_input;
   } result_type;
endpackage
`default_nettype wire

[rtl/core/rtq_core.sv]
`default_nettype none
// Pipelined datapath: setup, one sqrt bit per stage, one quotient bit per
// stage for the three dividers, then rounding and saturation.
module rtq_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            advance,
   input  wire logic                            in_valid,
   input  wire logic [9*rtq_pkg::DataWidth-1:0] in_data,
   output logic                                 out_valid,
   output rtq_pkg::result_type                  out_result
);
   localparam int DW = rtq_pkg::DataWidth;
   localparam int FB = rtq_pkg::FracBits;
   localparam int RW = rtq_pkg::RadWidth;
   localparam int TW = rtq_pkg::RootWidth;
   localparam int NW = rtq_pkg::NumWidth;
   localparam int VW = rtq_pkg::DivWidth;
   localparam int EW = rtq_pkg::DenWidth;
   localparam int QW = rtq_pkg::QuotWidth;
   localparam int SS = rtq_pkg::SqrtSteps;
   localparam int DS = rtq_pkg::DivSteps;
   localparam int RemW = TW + 2;
   localparam int PadW = 2 * TW;

   typedef struct packed {
      logic [PadW-1:0]   rad;
      logic [TW-1:0]     root;
      logic [RemW-1:0]   rem;
      rtq_pkg::sel_type  sel;
      logic              bad;
      logic [2:0]        neg;
      logic [3*VW-1:0]   mag;
   } sq_type;

   typedef struct packed {
      logic [EW-1:0]     den;
      logic [TW-1:0]     root;
      rtq_pkg::sel_type  sel;
      logic              bad;
      logic [2:0]        neg;
      logic [3*VW-1:0]   num;
      logic [3*(EW+1)-1:0] rem;
      logic [3*QW-1:0]   quo;
   } dv_type;

   logic signed [DW-1:0] m [9];
   always_comb begin
      for (int i = 0; i < 9; i++) begin
         m[i] = in_data[i*DW +: DW];
      end
   end

   // setup stage logic
   logic signed [RW-1:0] trace_c, rad_c;
   logic signed [NW-1:0] n_c [3];
   rtq_pkg::sel_type sel_c;
   logic signed [RW-1:0] one_c;
   always_comb begin
      one_c = RW'(1) <<< FB;
      trace_c = RW'(m[0]) + RW'(m[4]) + RW'(m[8]);
      if (trace_c > 0) begin
         sel_c = rtq_pkg::SEL_W;
         rad_c = one_c + trace_c;
         n_c[0] = NW'(m[5]) - NW'(m[7]);
         n_c[1] = NW'(m[6]) - NW'(m[2]);
         n_c[2] = NW'(m[1]) - NW'(m[3]);
      end else if (m[0] > m[4] && m[0] > m[8]) begin
         sel_c = rtq_pkg::SEL_X;
         rad_c = one_c + RW'(m[0]) - RW'(m[4]) - RW'(m[8]);
         n_c[0] = NW'(m[5]) - NW'(m[7]);
         n_c[1] = NW'(m[3]) + NW'(m[1]);
         n_c[2] = NW'(m[6]) + NW'(m[2]);
      end else if (m[4] > m[8]) begin
         sel_c = rtq_pkg::SEL_Y;
         rad_c = one_c + RW'(m[4]) - RW'(m[0]) - RW'(m[8]);
         n_c[0] = NW'(m[6]) - NW'(m[2]);
         n_c[1] = NW'(m[3]) + NW'(m[1]);
         n_c[2] = NW'(m[7]) + NW'(m[5]);
      end else begin
         sel_c = rtq_pkg::SEL_Z;
         rad_c = one_c + RW'(m[8]) - RW'(m[0]) - RW'(m[4]);
         n_c[0] = NW'(m[1]) - NW'(m[3]);
         n_c[1] = NW'(m[6]) + NW'(m[2]);
         n_c[2] = NW'(m[7]) + NW'(m[5]);
      end
   end

   sq_type sq_in;
   always_comb begin
      logic [NW-1:0] a;
      sq_in = '0;
      sq_in.sel = sel_c;
      sq_in.bad = (rad_c <= 0);
      sq_in.rad = sq_in.bad ? '0 : PadW'({rad_c[RW-2:0], {FB{1'b0}}});
      for (int k = 0; k < 3; k++) begin
         sq_in.neg[k] = n_c[k][NW-1];
         a = n_c[k][NW-1] ? NW'(-n_c[k]) : n_c[k];
         sq_in.mag[k*VW +: VW] = {a, {FB{1'b0}}};
      end
   end

   // sqrt pipeline, restoring, two radicand bits per stage
   sq_type sq_ff [SS+1];
   logic   sq_v_ff [SS+1];
   sq_type sq_nx [SS];
   always_comb begin
      for (int i = 0; i < SS; i++) begin
         logic [RemW-1:0] r2;
         logic [RemW-1:0] trial;
         sq_nx[i] = sq_ff[i];
         r2 = {sq_ff[i].rem[RemW-3:0], sq_ff[i].rad[PadW-1 -: 2]};
         trial = RemW'({sq_ff[i].root, 2'b01});
         sq_nx[i].rad = {sq_ff[i].rad[PadW-3:0], 2'b00};
         if (r2 >= trial) begin
            sq_nx[i].rem = r2 - trial;
            sq_nx[i].root = {sq_ff[i].root[TW-2:0], 1'b1};
         end else begin
            sq_nx[i].rem = r2;
            sq_nx[i].root = {sq_ff[i].root[TW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sq_ff[0] <= sq_in;
         for (int i = 0; i < SS; i++) sq_ff[i+1] <= sq_nx[i];
      end
      if (reset) begin
         for (int i = 0; i <= SS; i++) sq_v_ff[i] <= 1'b0;
      end else if (advance) begin
         sq_v_ff[0] <= in_valid;
         for (int i = 0; i < SS; i++) sq_v_ff[i+1] <= sq_v_ff[i];
      end
   end

   // divider entry: den = 2t, dividends get n*ONE + den/2 for rounding
   dv_type dv_in;
   always_comb begin
      logic [EW-1:0] d;
      dv_in = '0;
      d = {sq_ff[SS].root, 1'b0};
      dv_in.den = d;
      dv_in.root = sq_ff[SS].root;
      dv_in.sel = sq_ff[SS].sel;
      dv_in.bad = sq_ff[SS].bad;
      dv_in.neg = sq_ff[SS].neg;
      for (int k = 0; k < 3; k++) begin
         dv_in.num[k*VW +: VW] = sq_ff[SS].mag[k*VW +: VW] + VW'(d >> 1);
      end
   end

   dv_type dv_ff [DS+1];
   logic   dv_v_ff [DS+1];
   dv_type dv_nx [DS];
   always_comb begin
      for (int i = 0; i < DS; i++) begin
         dv_nx[i] = dv_ff[i];
         for (int k = 0; k < 3; k++) begin
            logic [EW:0] r2;
            logic [VW-1:0] nm;
            nm = dv_ff[i].num[k*VW +: VW];
            r2 = {dv_ff[i].rem[k*(EW+1) +: EW], nm[VW-1]};
            dv_nx[i].num[k*VW +: VW] = {nm[VW-2:0], 1'b0};
            if (r2 >= {1'b0, dv_ff[i].den}) begin
               dv_nx[i].rem[k*(EW+1) +: EW+1] = r2 - {1'b0, dv_ff[i].den};
               dv_nx[i].quo[k*QW +: QW] = {dv_ff[i].quo[k*QW +: QW-1], 1'b1};
            end else begin
               dv_nx[i].rem[k*(EW+1) +: EW+1] = r2;
               dv_nx[i].quo[k*QW +: QW] = {dv_ff[i].quo[k*QW +: QW-1], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dv_ff[0] <= dv_in;
         for (int i = 0; i < DS; i++) dv_ff[i+1] <= dv_nx[i];
      end
      if (reset) begin
         for (int i = 0; i <= DS; i++) dv_v_ff[i] <= 1'b0;
      end else if (advance) begin
         dv_v_ff[0] <= sq_v_ff[SS];
         for (int i = 0; i < DS; i++) dv_v_ff[i+1] <= dv_v_ff[i];
      end
   end

   // final: sign, saturate, place components by branch
   localparam logic [QW-1:0] SMaxQ = QW'((64'd1 << (DW - 1)) - 64'd1);
   rtq_pkg::result_type res_in, res_ff;
   logic res_v_ff;
   always_comb begin
      logic [DW-1:0] o [3];
      logic [DW-1:0] own;
      logic [QW-1:0] q;
      logic [TW:0] tp;
      for (int k = 0; k < 3; k++) begin
         q = dv_ff[DS].quo[k*QW +: QW];
         if (dv_ff[DS].neg[k]) begin
            o[k] = (q > SMaxQ) ? {1'b1, {(DW-1){1'b0}}} : DW'(-q);
         end else begin
            o[k] = (q > SMaxQ) ? SMaxQ[DW-1:0] : q[DW-1:0];
         end
      end
      tp = ({1'b0, dv_ff[DS].root} + 1'b1) >> 1;
      own = (tp > (TW+1)'(SMaxQ)) ? SMaxQ[DW-1:0] : DW'(tp);
      res_in = '0;
      unique case (dv_ff[DS].sel)
         rtq_pkg::SEL_W: begin
            res_in.quat_w = own; res_in.quat_x = o[0];
            res_in.quat_y = o[1]; res_in.quat_z = o[2];
         end
         rtq_pkg::SEL_X: begin
            res_in.quat_w = o[0]; res_in.quat_x = own;
            res_in.quat_y = o[1]; res_in.quat_z = o[2];
         end
         rtq_pkg::SEL_Y: begin
            res_in.quat_w = o[0]; res_in.quat_x = o[1];
            res_in.quat_y = own; res_in.quat_z = o[2];
         end
         default: begin
            res_in.quat_w = o[0]; res_in.quat_x = o[1];
            res_in.quat_y = o[2]; res_in.quat_z = own;
         end
      endcase
      if (dv_ff[DS].bad) begin
         res_in = '0;
         res_in.bad_input = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) res_ff <= res_in;
      if (reset) res_v_ff <= 1'b0;
      else if (advance) res_v_ff <= dv_v_ff[DS];
   end

   assign out_valid = res_v_ff;
   assign out_result = res_ff;
endmodule
`default_nettype wire

[rtl/core/rotation_axes_to_quaternion_unit.sv]
`default_nettype none
// Rotation matrix to unit quaternion. Accepts one matrix per cycle while
// the result side does not stall; each result passes through one setup
// stage, one stage per root bit of the bit-serial square root (RootWidth
// stages), one divider entry stage, one stage per quotient bit of the three
// parallel dividers (DivWidth stages), and one output stage.
// The whole pipeline holds when the result side stalls, so no transfer is
// lost or repeated; the pipeline advances whenever the output register is
// empty or drains.
module rotation_axes_to_quaternion_unit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // xaxis_x, xaxis_y, xaxis_z, yaxis_x, yaxis_y, yaxis_z, zaxis_x, zaxis_y, zaxis_z
   input  wire logic [9*rtq_pkg::DataWidth-1:0] req_tdata,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // quat_w, quat_x, quat_y, quat_z
   output logic [4*rtq_pkg::DataWidth-1:0]      rsp_tdata,
   // bad_input
   output logic                                 rsp_tuser
);
   logic advance;
   rtq_pkg::result_type res;

   // advance whenever the output slot is free or being taken
   assign advance = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   rtq_core u_core (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (req_tvalid),
      .in_data    (req_tdata),
      .out_valid  (rsp_tvalid),
      .out_result (res)
   );

   assign rsp_tdata = {res.quat_z, res.quat_y, res.quat_x, res.quat_w};
   assign rsp_tuser = res.bad_input;

`ifndef SYNTH
   a_ready_rule: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("ready not tied to output slot");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("bad input with nonzero quaternion");
`endif
endmodule
`default_nettype wire

[bench/testbench.sv]
`default_nettype none
module testbench;
   localparam int W = rtq_pkg::DataWidth;
   localparam longint OneFx = longint'(1) << rtq_pkg::FracBits;
   localparam longint SatMax = (longint'(1) << (W - 1)) - 1;
   localparam longint SatMin = -SatMax - 1;
   // drain time and watchdog limit, both well beyond the pipeline depth
   localparam int DrainCycles = 200;
   localparam int StallLimit = 5000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [9*W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [4*W-1:0] rsp_tdata;
   logic rsp_tuser;

   rtq_pkg::result_type quat_expected[$];
   int error_count = 0;
   int idle_cycles = 0;
   bit send_gaps = 1'b1;
   bit recv_gaps = 1'b1;
   bit recv_hold = 1'b0;

   rotation_axes_to_quaternion_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [W-1:0] saturate(longint v);
      if (v > SatMax) return SatMax[W-1:0];
      if (v < SatMin) return SatMin[W-1:0];
      return v[W-1:0];
   endfunction

   // floor square root by bisection
   function automatic longint floor_root(longint v);
      longint lo, hi, mid;
      lo = 0;
      hi = 32'hFFFF_FFFF;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         if (mid * mid <= v) lo = mid;
         else hi = mid - 1;
      end
      return lo;
   endfunction

   // (n * ONE) / den, nearest, ties away from zero
   function automatic longint scaled_div(longint n, longint den);
      longint mag, q;
      mag = (n < 0) ? -n : n;
      q = (mag * OneFx + den / 2) / den;
      return (n < 0) ? -q : q;
   endfunction

   function automatic rtq_pkg::result_type axes_to_quat(logic [9*W-1:0] mat);
      longint m[9];
      longint tr, rad, root;
      longint num[4];
      rtq_pkg::sel_type branch;
      rtq_pkg::result_type res;
      for (int i = 0; i < 9; i++) m[i] = longint'($signed(mat[i*W +: W]));
      tr = m[0] + m[4] + m[8];
      num = '{0, 0, 0, 0};
      if (tr > 0) begin
         branch = rtq_pkg::SEL_W;
         rad = OneFx + tr;
         num[1] = m[5] - m[7]; num[2] = m[6] - m[2]; num[3] = m[1] - m[3];
      end else if (m[0] > m[4] && m[0] > m[8]) begin
         branch = rtq_pkg::SEL_X;
         rad = OneFx + m[0] - m[4] - m[8];
         num[0] = m[5] - m[7]; num[2] = m[3] + m[1]; num[3] = m[6] + m[2];
      end else if (m[4] > m[8]) begin
         branch = rtq_pkg::SEL_Y;
         rad = OneFx + m[4] - m[0] - m[8];
         num[0] = m[6] - m[2]; num[1] = m[3] + m[1]; num[3] = m[7] + m[5];
      end else begin
         branch = rtq_pkg::SEL_Z;
         rad = OneFx + m[8] - m[0] - m[4];
         num[0] = m[1] - m[3]; num[1] = m[6] + m[2]; num[2] = m[7] + m[5];
      end
      res = '0;
      if (rad <= 0) begin
         res.bad_input = 1'b1;
         return res;
      end
      root = floor_root(rad * OneFx);
      for (int k = 0; k < 4; k++)
         num[k] = (k == int'(branch)) ? (root + 1) >>> 1 : scaled_div(num[k], 2 * root);
      res.quat_w = saturate(num[0]);
      res.quat_x = saturate(num[1]);
      res.quat_y = saturate(num[2]);
      res.quat_z = saturate(num[3]);
      return res;
   endfunction

   // send one matrix and queue its expected quaternion on transfer;
   // valid stays up after the transfer until a gap or the end of the run
   task automatic send_matrix(logic [9*W-1:0] mat);
      while (send_gaps && $urandom_range(99) < 30) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= mat;
      do @(posedge clock); while (!req_tready);
      quat_expected.push_back(axes_to_quat(mat));
   endtask

   function automatic logic [9*W-1:0] pack_matrix(longint e[9]);
      logic [9*W-1:0] mat;
      for (int i = 0; i < 9; i++) mat[i*W +: W] = e[i][W-1:0];
      return mat;
   endfunction

   // rotation about a random axis plus jitter, built from floats
   function automatic logic [9*W-1:0] near_rotation(int jitter);
      real a, b, c, n, ang, co, si, v;
      real r[9];
      longint e[9];
      a = real'($urandom_range(2000)) - 1000.0;
      b = real'($urandom_range(2000)) - 1000.0;
      c = real'($urandom_range(2000)) - 1000.0;
      n = $sqrt(a*a + b*b + c*c);
      if (n < 1.0) begin a = 1.0; n = 1.0; end
      a /= n; b /= n; c /= n;
      ang = real'($urandom_range(62832)) / 10000.0;
      co = $cos(ang); si = $sin(ang);
      r = '{co + a*a*(1-co), a*b*(1-co) - c*si, a*c*(1-co) + b*si,
            b*a*(1-co) + c*si, co + b*b*(1-co), b*c*(1-co) - a*si,
            c*a*(1-co) - b*si, c*b*(1-co) + a*si, co + c*c*(1-co)};
      for (int i = 0; i < 9; i++) begin
         v = r[i] * real'(OneFx);
         e[i] = longint'(v) + longint'($urandom_range(2*jitter)) - jitter;
      end
      return pack_matrix(e);
   endfunction

   function automatic logic [9*W-1:0] random_matrix();
      logic [9*W-1:0] mat;
      for (int i = 0; i < 9; i++) mat[i*W +: W] = W'($urandom);
      return mat;
   endfunction

   task automatic test_directed();
      longint e[9];
      // identity and the half-turns, one for each branch
      send_matrix(pack_matrix('{OneFx, 0, 0, 0, OneFx, 0, 0, 0, OneFx}));
      send_matrix(pack_matrix('{OneFx, 0, 0, 0, -OneFx, 0, 0, 0, -OneFx}));
      send_matrix(pack_matrix('{-OneFx, 0, 0, 0, OneFx, 0, 0, 0, -OneFx}));
      send_matrix(pack_matrix('{-OneFx, 0, 0, 0, -OneFx, 0, 0, 0, OneFx}));
      // all zero: trace zero, ties fall to the z branch
      send_matrix('0);
      // all ones (minus one in every entry), then extremes everywhere
      send_matrix({9*W{1'b1}});
      send_matrix(pack_matrix('{SatMax, SatMax, SatMax, SatMax, SatMax,
                                SatMax, SatMax, SatMax, SatMax}));
      send_matrix(pack_matrix('{SatMin, SatMin, SatMin, SatMin, SatMin,
                                SatMin, SatMin, SatMin, SatMin}));
      // all-negative diagonals, which fall to the z branch
      send_matrix(pack_matrix('{-OneFx, 0, 0, 0, -OneFx, 0, 0, 0, -OneFx}));
      send_matrix(pack_matrix('{SatMin, 0, 0, 0, SatMin, 0, 0, 0, SatMin}));
      // diagonal near minus one with full-scale off-diagonals
      send_matrix(pack_matrix('{-OneFx + 1, SatMax, SatMin, SatMin, 0, SatMax,
                                SatMax, SatMin, -OneFx + 1}));
      send_matrix(pack_matrix('{0, SatMin, SatMax, SatMax, -OneFx + 1, SatMin,
                                SatMin, SatMax, -OneFx + 1}));
      // alternating bit patterns
      e = '{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
            16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555};
      send_matrix(pack_matrix(e));
      for (int i = 0; i < 9; i++) e[i] = ~e[i];
      send_matrix(pack_matrix(e));
   endtask

   task automatic test_random(int count);
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(9))
            0, 1: send_matrix(random_matrix());
            2: send_matrix(near_rotation(2000));
            default: send_matrix(near_rotation(4));
         endcase
      end
   endtask

   // hold off the receiver for a long stretch while the sender keeps offering
   task automatic test_backpressure();
      recv_hold = 1'b1;
      send_gaps = 1'b0;
      fork
         begin
            repeat (400) @(posedge clock);
            recv_hold = 1'b0;
         end
      join_none
      test_random(150);
      send_gaps = 1'b1;
   endtask

   task automatic test_no_gaps();
      send_gaps = 1'b0;
      recv_gaps = 1'b0;
      test_random(120);
      send_gaps = 1'b1;
      recv_gaps = 1'b1;
   endtask

   // drive the receiver ready at each rising edge
   always @(posedge clock) begin
      if (reset || recv_hold) rsp_tready <= 1'b0;
      else rsp_tready <= !(recv_gaps && $urandom_range(99) < 30);
   end

   // check each transfer against the oldest expected quaternion
   always @(posedge clock) begin
      rtq_pkg::result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[W-1:0], rsp_tdata[2*W-1:W], rsp_tdata[3*W-1:2*W],
                rsp_tdata[4*W-1:3*W], rsp_tuser};
         if (quat_expected.size() == 0) begin
            $error("unexpected result %h", got);
            error_count++;
         end else begin
            want = quat_expected.pop_front();
            if (got.quat_w !== want.quat_w) begin
               $error("quat_w: expected %h, got %h", want.quat_w, got.quat_w);
               error_count++;
            end
            if (got.quat_x !== want.quat_x) begin
               $error("quat_x: expected %h, got %h", want.quat_x, got.quat_x);
               error_count++;
            end
            if (got.quat_y !== want.quat_y) begin
               $error("quat_y: expected %h, got %h", want.quat_y, got.quat_y);
               error_count++;
            end
            if (got.quat_z !== want.quat_z) begin
               $error("quat_z: expected %h, got %h", want.quat_z, got.quat_z);
               error_count++;
            end
            if (got.bad_input !== want.bad_input) begin
               $error("bad_input: expected %b, got %b", want.bad_input, got.bad_input);
               error_count++;
            end
         end
      end
   end

   // count cycles with no transfer on either side; give up at the limit
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(300);
      test_backpressure();
      test_no_gaps();
      req_tvalid <= 1'b0;
      while (quat_expected.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule
`default_nettype wire
